>>> rtl/core/tcfp_pkg.sv
// Shared types, codes and character constants for the tagged control frame parser.
// No dependencies; imported by tcfp_num and tagged_control_frame_parser_unit.
package tcfp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 255;
    localparam int unsigned NUM_TAGS         = 10;
    localparam int unsigned NUM_VALUES       = 7;
    localparam int unsigned NUM_FLAGS        = 3;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_acc;
    typedef logic [3:0]  t_phase;
    typedef logic [2:0]  t_status;

    // parse phase: 0..10 is the count of tags seen
    localparam t_phase PH_START  = 4'd0;
    localparam t_phase PH_LAST   = 4'd10;
    localparam t_phase PH_CHK_OK = 4'd11;
    localparam t_phase PH_CHK_BAD = 4'd12;
    localparam t_phase PH_FAULT  = 4'd13;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_SHORT     = 3'd1;
    localparam t_status ST_NO_TERM   = 3'd2;
    localparam t_status ST_BAD_CHK   = 3'd3;
    localparam t_status ST_TAG_FAULT = 3'd4;

    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_PLUS  = 8'h2b;
    localparam t_byte CH_MINUS = 8'h2d;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;

    localparam t_acc ACC_SAT  = 16'd32768;
    localparam t_acc VAL_MAX  = 16'd32767;
    localparam t_acc SURF_CTR = 16'd90;

    typedef struct packed {
        logic neg;
        logic begun;
        logic stop;
    } t_num_flags;

    function automatic t_byte tag_letter(input t_phase idx);
        t_byte c;
        case (idx)
            4'd0:    c = 8'h65; // e
            4'd1:    c = 8'h61; // a
            4'd2:    c = 8'h72; // r
            4'd3:    c = 8'h6c; // l
            4'd4:    c = 8'h74; // t
            4'd5:    c = 8'h69; // i
            4'd6:    c = 8'h66; // f
            4'd7:    c = 8'h7a; // z
            4'd8:    c = 8'h79; // y
            4'd9:    c = 8'h62; // b
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_tag(input t_byte c);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < NUM_TAGS; k++) begin
            if (c == tag_letter(4'(k))) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/tagged_control_frame_parser_unit.sv
// Top level of the tagged control frame parser: byte handshake, frame state,
// pending and held values, result register. Uses tcfp_pkg and tcfp_num.
//
//  channel   direction  handshake                 payload
//  ------    ---------  ------------------------  -----------------------------------
//  in        sink       i_in_valid / o_in_ready    i_data_byte, i_last_byte
//  out       source     o_out_valid / i_out_ready  o_status, held values and flags
//  cfg       sink       i_cfg_we                   i_cfg_wdata (min_length)
//
// One byte is taken per cycle; the frame state updates at the edge that takes it.
// A final byte loads the result register at the edge that takes it; the result is
// offered from the next cycle. Bytes that are not final keep flowing while a result
// waits. Only a final byte stalls, until the previous result is taken.
// Synchronous active-low reset; no clearing pass.
module tagged_control_frame_parser_unit #(
    parameter int unsigned MAX_BYTES = tcfp_pkg::MAX_PACKET_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  tcfp_pkg::t_byte        i_data_byte,
    input  logic                   i_last_byte,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_wdata,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output tcfp_pkg::t_status      o_status,
    output logic signed [15:0]     o_engine,
    output logic signed [15:0]     o_aileron,
    output logic signed [15:0]     o_rudder,
    output logic signed [15:0]     o_elevator,
    output logic signed [15:0]     o_elevator_trim,
    output logic signed [15:0]     o_aileron_trim,
    output logic signed [15:0]     o_flaps,
    output logic                   o_reset_aileron_trim,
    output logic                   o_reset_elevator_trim,
    output logic                   o_airbrake
);
    import tcfp_pkg::*;

    logic [7:0] r_min_length;
    logic [7:0] r_byte_count, n_byte_count;
    t_byte      r_xor, n_xor;
    t_phase     r_phase, n_phase;
    t_acc       r_acc, n_acc;
    t_num_flags r_flags, n_flags;
    t_acc       r_pend_num  [NUM_VALUES];
    t_acc       n_pend_num  [NUM_VALUES];
    logic       r_pend_flag [NUM_FLAGS];
    logic       n_pend_flag [NUM_FLAGS];
    t_acc       r_held_num  [NUM_VALUES];
    logic       r_held_flag [NUM_FLAGS];
    logic       r_out_valid;
    t_status    r_status, n_status;

    logic       in_fire;
    logic       cnt_open;
    logic       do_close;
    t_phase     close_idx;
    t_phase     flag_idx;
    t_acc       close_num;
    logic       close_flag;
    logic       in_chk;
    t_acc       num_acc;
    t_num_flags num_flags;
    t_byte      rx_chk;

    assign o_in_ready = !r_out_valid || i_out_ready || !i_last_byte;
    assign in_fire    = i_in_valid && o_in_ready;
    assign cnt_open   = r_byte_count < 8'(MAX_BYTES);
    assign in_chk     = (r_phase == PH_CHK_OK) || (r_phase == PH_CHK_BAD);

    tcfp_num u_num (
        .i_char   (i_data_byte),
        .i_mod256 (in_chk),
        .i_acc    (r_acc),
        .i_flags  (r_flags),
        .o_acc    (num_acc),
        .o_flags  (num_flags)
    );

    // value of the field now closing, from the state before this byte
    always_comb begin
        if (r_flags.neg) begin
            close_num = 16'(~r_acc + 16'd1);
        end else if (r_acc > VAL_MAX) begin
            close_num = VAL_MAX;
        end else begin
            close_num = r_acc;
        end
        close_flag = (r_acc != 16'd0);
        close_idx  = 4'(r_phase - 4'd1);
        flag_idx   = 4'(close_idx - 4'(NUM_VALUES));
    end

    // frame state for one byte
    always_comb begin
        n_byte_count = r_byte_count;
        n_xor        = r_xor;
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_flags      = r_flags;
        do_close     = 1'b0;
        if (cnt_open) begin
            n_byte_count = 8'(r_byte_count + 8'd1);
            if (in_chk) begin
                n_acc   = num_acc;
                n_flags = num_flags;
            end else if (i_data_byte == CH_HASH) begin
                do_close = (r_phase >= 4'd1) && (r_phase <= PH_LAST);
                n_phase  = (r_phase == PH_LAST) ? PH_CHK_OK : PH_CHK_BAD;
                n_acc    = '0;
                n_flags  = '0;
            end else begin
                n_xor = r_xor ^ i_data_byte;
                if (r_phase <= PH_LAST) begin
                    if (is_tag(i_data_byte)) begin
                        if (r_phase < PH_LAST && i_data_byte == tag_letter(r_phase)) begin
                            do_close = (r_phase != PH_START);
                            n_phase  = 4'(r_phase + 4'd1);
                            n_acc    = '0;
                            n_flags  = '0;
                        end else begin
                            n_phase = PH_FAULT;
                        end
                    end else if (r_phase != PH_START) begin
                        n_acc   = num_acc;
                        n_flags = num_flags;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_VALUES; k++) n_pend_num[k] = r_pend_num[k];
        for (int k = 0; k < NUM_FLAGS; k++) n_pend_flag[k] = r_pend_flag[k];
        if (do_close) begin
            if (close_idx < 4'(NUM_VALUES)) begin
                n_pend_num[close_idx[2:0]] = close_num;
            end else begin
                n_pend_flag[flag_idx[1:0]] = close_flag;
            end
        end
    end

    // end-of-frame checks, lowest fault code wins
    always_comb begin
        rx_chk = n_flags.neg ? 8'(8'd0 - n_acc[7:0]) : n_acc[7:0];
        if (n_byte_count < r_min_length) begin
            n_status = ST_SHORT;
        end else if (n_phase != PH_CHK_OK && n_phase != PH_CHK_BAD) begin
            n_status = ST_NO_TERM;
        end else if (rx_chk != n_xor) begin
            n_status = ST_BAD_CHK;
        end else if (n_phase == PH_CHK_BAD) begin
            n_status = ST_TAG_FAULT;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= 8'd10;
        end else if (i_cfg_we) begin
            r_min_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_xor        <= '0;
            r_phase      <= PH_START;
            r_acc        <= '0;
            r_flags      <= '0;
        end else if (in_fire) begin
            if (i_last_byte) begin
                r_byte_count <= '0;
                r_xor        <= '0;
                r_phase      <= PH_START;
                r_acc        <= '0;
                r_flags      <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_xor        <= n_xor;
                r_phase      <= n_phase;
                r_acc        <= n_acc;
                r_flags      <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VALUES; k++) r_pend_num[k] <= '0;
            for (int k = 0; k < NUM_FLAGS; k++) r_pend_flag[k] <= 1'b0;
        end else if (in_fire) begin
            r_pend_num  <= n_pend_num;
            r_pend_flag <= n_pend_flag;
        end
    end

    // held values change only when a result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_num[0] <= '0;
            r_held_num[1] <= SURF_CTR;
            r_held_num[2] <= SURF_CTR;
            r_held_num[3] <= SURF_CTR;
            r_held_num[4] <= '0;
            r_held_num[5] <= '0;
            r_held_num[6] <= '0;
            for (int k = 0; k < NUM_FLAGS; k++) r_held_flag[k] <= 1'b0;
        end else if (in_fire && i_last_byte && n_status == ST_OK) begin
            r_held_num  <= n_pend_num;
            r_held_flag <= n_pend_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_last_byte) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_engine              = r_held_num[0];
    assign o_aileron             = r_held_num[1];
    assign o_rudder              = r_held_num[2];
    assign o_elevator            = r_held_num[3];
    assign o_elevator_trim       = r_held_num[4];
    assign o_aileron_trim        = r_held_num[5];
    assign o_flaps               = r_held_num[6];
    assign o_reset_aileron_trim  = r_held_flag[0];
    assign o_reset_elevator_trim = r_held_flag[1];
    assign o_airbrake            = r_held_flag[2];

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_last_byte |=> r_byte_count == 8'd0 && r_phase == PH_START)
        else $error("frame state not cleared after final item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= 8'(MAX_BYTES))
        else $error("byte count past limit");

    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_fire && i_last_byte) |=> $stable(r_held_num[0]) && $stable(r_held_flag[2]))
        else $error("held value changed without a result");

    a_ok_needs_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_last_byte && n_status == ST_OK |-> n_phase == PH_CHK_OK)
        else $error("good status without all tags");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_fire && i_last_byte))
        else $error("result raised without a final item");

endmodule

>>> rtl/core/tcfp_num.sv
// Decimal number step: advances a signed decimal value by one character.
// Saturates at 32768 for fields, wraps modulo 256 for the checksum. Uses tcfp_pkg.
module tcfp_num (
    input  tcfp_pkg::t_byte      i_char,
    input  logic                 i_mod256,
    input  tcfp_pkg::t_acc       i_acc,
    input  tcfp_pkg::t_num_flags i_flags,
    output tcfp_pkg::t_acc       o_acc,
    output tcfp_pkg::t_num_flags o_flags
);
    import tcfp_pkg::*;

    logic        is_digit;
    logic [19:0] prod;
    logic [3:0]  digit;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit    = 4'(i_char - CH_ZERO);
    assign prod     = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + {16'd0, digit};

    always_comb begin
        o_acc   = i_acc;
        o_flags = i_flags;
        if (!i_flags.stop) begin
            if (is_digit) begin
                o_flags.begun = 1'b1;
                if (i_mod256) begin
                    o_acc = {8'd0, prod[7:0]};
                end else if (prod > {4'd0, ACC_SAT}) begin
                    o_acc = ACC_SAT;
                end else begin
                    o_acc = prod[15:0];
                end
            end else if ((i_char == CH_PLUS || i_char == CH_MINUS) && !i_flags.begun) begin
                o_flags.begun = 1'b1;
                if (i_char == CH_MINUS) o_flags.neg = 1'b1;
            end else begin
                o_flags.stop = 1'b1;
            end
        end
    end

endmodule

>>> verif/tagged_control_frame_parser_unit_tb.sv
// Self-checking testbench for tagged_control_frame_parser_unit: a table of directed frames,
// then random frames over several min_length settings, checked by an in-bench frame model.
// Depends on tcfp_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tagged_control_frame_parser_unit_tb;
    import tcfp_pkg::*;

    typedef enum {TAIL_NONE, TAIL_GOOD, TAIL_BAD, TAIL_NEG, TAIL_WRAP, TAIL_HASH2, TAIL_BARE}
        t_tail_form;
    typedef enum {FAULT_NONE, FAULT_SWAP, FAULT_SKIP, FAULT_REPEAT, FAULT_STRAY} t_fault;

    typedef struct packed {
        t_status          status;
        logic [6:0][15:0] values;
        logic [2:0]       flags;
    } t_frame_result;

    typedef struct packed {
        bit      typed;
        t_status status;
    } t_row_note;

    typedef struct {
        string      body;
        t_tail_form tail;
        bit         typed;
        t_status    status;
    } t_frame_row;

    localparam logic [7:0] FRAME_TAGS [10] = '{"e", "a", "r", "l", "t", "i", "f", "z", "y", "b"};

    string value_names [7] = '{"engine", "aileron", "rudder", "elevator", "elevator_trim",
                               "aileron_trim", "flaps"};
    string flag_names [3] = '{"reset_aileron_trim", "reset_elevator_trim", "airbrake"};

    // expected status typed in where the fault is plain; other rows rely on the model
    t_frame_row frame_rows [13] = '{
        '{"k",                                        TAIL_NONE,  1'b1, ST_SHORT},
        '{"e1a2r3l4t5i6f7z1y0b1",                     TAIL_NONE,  1'b1, ST_NO_TERM},
        '{"e100a90r80l70t-1i1f4z1y0b1",               TAIL_GOOD,  1'b1, ST_OK},
        '{"e5a91r89l95t0i0f2z0y1b0",                  TAIL_BAD,   1'b1, ST_BAD_CHK},
        '{"a1e2r3l4t5i6f7z1y0b1",                     TAIL_GOOD,  1'b1, ST_TAG_FAULT},
        '{"e1e2a3r4l5t6i7f0z0y0b0",                   TAIL_GOOD,  1'b1, ST_TAG_FAULT},
        '{"e1a2r3l4t5i6f7z1y0",                       TAIL_GOOD,  1'b1, ST_TAG_FAULT},
        '{"e1",                                       TAIL_GOOD,  1'b1, ST_SHORT},
        '{"e32767a-32768r99999l-99999t+5i--3f7+2z0y5b-0", TAIL_GOOD, 1'b0, ST_OK},
        '{"QQ!e-a+r00090l0090t1i-1f3z70000y0b+1",     TAIL_NEG,   1'b0, ST_OK},
        '{"e12a34r56l78t1i1f1z1y1b1",                 TAIL_WRAP,  1'b0, ST_OK},
        '{"e7a8r9l1t2i3f4z5y6b7",                     TAIL_HASH2, 1'b0, ST_OK},
        '{"e\377a 12r9x9l3\tt1i1f1z0y0b0",            TAIL_GOOD,  1'b0, ST_OK}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_byte             i_data_byte;
    logic              i_last_byte;
    logic              i_cfg_we;
    logic [7:0]        i_cfg_wdata;
    logic              o_out_valid;
    logic              i_out_ready;
    t_status           o_status;
    logic signed [15:0] o_engine;
    logic signed [15:0] o_aileron;
    logic signed [15:0] o_rudder;
    logic signed [15:0] o_elevator;
    logic signed [15:0] o_elevator_trim;
    logic signed [15:0] o_aileron_trim;
    logic signed [15:0] o_flaps;
    logic              o_reset_aileron_trim;
    logic              o_reset_elevator_trim;
    logic              o_airbrake;

    // frame model state
    logic [7:0]  min_len;
    int unsigned pkt_count;
    logic [7:0]  pkt_xor;
    t_phase      frame_phase;
    int unsigned acc;
    logic        num_neg;
    logic        num_begun;
    logic        num_stop;
    logic [15:0] pend_vals [10];
    logic [15:0] held_vals [10];

    t_frame_result frames_due [$];
    t_row_note     row_notes [$];
    logic [7:0]    pkt [$];

    int          errors;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    bit          quiet;
    bit          hold_request;

    tagged_control_frame_parser_unit uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_data_byte           (i_data_byte),
        .i_last_byte           (i_last_byte),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_status              (o_status),
        .o_engine              (o_engine),
        .o_aileron             (o_aileron),
        .o_rudder              (o_rudder),
        .o_elevator            (o_elevator),
        .o_elevator_trim       (o_elevator_trim),
        .o_aileron_trim        (o_aileron_trim),
        .o_flaps               (o_flaps),
        .o_reset_aileron_trim  (o_reset_aileron_trim),
        .o_reset_elevator_trim (o_reset_elevator_trim),
        .o_airbrake            (o_airbrake)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(3_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit is_frame_tag(input logic [7:0] c);
        bit hit;
        hit = 1'b0;
        foreach (FRAME_TAGS[k]) if (FRAME_TAGS[k] == c) hit = 1'b1;
        return hit;
    endfunction

    function automatic void clear_packet();
        pkt_count   = 0;
        pkt_xor     = 8'd0;
        frame_phase = PH_START;
        acc         = 0;
        num_neg     = 1'b0;
        num_begun   = 1'b0;
        num_stop    = 1'b0;
    endfunction

    function automatic void reset_model();
        min_len = 8'd10;
        clear_packet();
        foreach (pend_vals[k]) begin
            pend_vals[k] = 16'd0;
            held_vals[k] = 16'd0;
        end
        held_vals[1] = 16'd90;
        held_vals[2] = 16'd90;
        held_vals[3] = 16'd90;
    endfunction

    // field values saturate; the checksum wraps modulo 256
    function automatic void take_numeral(input logic [7:0] c, input bit wrap);
        int unsigned a;
        if (!num_stop) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                a = acc * 10 + 32'(c - CH_ZERO);
                if (wrap) a = a & 32'hFF;
                else if (a > 32768) a = 32768;
                acc       = a;
                num_begun = 1'b1;
            end else if ((c == CH_PLUS || c == CH_MINUS) && !num_begun) begin
                num_begun = 1'b1;
                if (c == CH_MINUS) num_neg = 1'b1;
            end else begin
                num_stop = 1'b1;
            end
        end
    endfunction

    function automatic void latch_field(input int k);
        int v;
        v = int'(acc);
        if (num_neg) v = -v;
        else if (v > 32767) v = 32767;
        if (k >= 7) v = (v != 0) ? 1 : 0;
        pend_vals[k] = v[15:0];
    endfunction

    function automatic void feed_byte(input logic [7:0] c);
        if (frame_phase == PH_CHK_OK || frame_phase == PH_CHK_BAD) begin
            take_numeral(c, 1'b1);
        end else if (c == CH_HASH) begin
            if (frame_phase >= 4'd1 && frame_phase <= PH_LAST)
                latch_field(int'(frame_phase) - 1);
            frame_phase = (frame_phase == PH_LAST) ? PH_CHK_OK : PH_CHK_BAD;
            acc       = 0;
            num_neg   = 1'b0;
            num_begun = 1'b0;
            num_stop  = 1'b0;
        end else begin
            pkt_xor = pkt_xor ^ c;
            if (frame_phase <= PH_LAST) begin
                if (is_frame_tag(c)) begin
                    if (frame_phase < PH_LAST && c == FRAME_TAGS[frame_phase]) begin
                        if (frame_phase != PH_START) latch_field(int'(frame_phase) - 1);
                        frame_phase = frame_phase + 4'd1;
                        acc       = 0;
                        num_neg   = 1'b0;
                        num_begun = 1'b0;
                        num_stop  = 1'b0;
                    end else begin
                        frame_phase = PH_FAULT;
                    end
                end else if (frame_phase != PH_START) begin
                    take_numeral(c, 1'b0);
                end
            end
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] c, input logic lst);
        t_frame_result res;
        logic [7:0]    rx;
        t_row_note     note;
        if (pkt_count < MAX_PACKET_BYTES) begin
            pkt_count++;
            feed_byte(c);
        end
        if (lst) begin
            rx = acc[7:0];
            if (num_neg) rx = 8'd0 - rx;
            if (pkt_count < min_len) res.status = ST_SHORT;
            else if (frame_phase != PH_CHK_OK && frame_phase != PH_CHK_BAD)
                res.status = ST_NO_TERM;
            else if (rx != pkt_xor) res.status = ST_BAD_CHK;
            else if (frame_phase == PH_CHK_BAD) res.status = ST_TAG_FAULT;
            else res.status = ST_OK;
            if (res.status == ST_OK) held_vals = pend_vals;
            for (int k = 0; k < 7; k++) res.values[k] = held_vals[k];
            for (int k = 0; k < 3; k++) res.flags[k] = held_vals[7 + k][0];
            if (row_notes.size() != 0) begin
                note = row_notes.pop_front();
                if (note.typed) res.status = note.status;
            end
            frames_due.push_back(res);
            clear_packet();
        end
    endfunction

    function automatic void check_frame();
        t_frame_result got;
        t_frame_result want;
        got.status = o_status;
        got.values = {o_flaps, o_aileron_trim, o_elevator_trim, o_elevator, o_rudder,
                      o_aileron, o_engine};
        got.flags  = {o_airbrake, o_reset_elevator_trim, o_reset_aileron_trim};
        if (frames_due.size() == 0) begin
            errors++;
            $error("result with none expected: status %0d", got.status);
        end else begin
            want = frames_due.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            for (int k = 0; k < 7; k++) begin
                if (got.values[k] !== want.values[k]) begin
                    errors++;
                    $error("%s: expected %0d, got %0d", value_names[k],
                           $signed(want.values[k]), $signed(got.values[k]));
                end
            end
            for (int k = 0; k < 3; k++) begin
                if (got.flags[k] !== want.flags[k]) begin
                    errors++;
                    $error("%s: expected %0d, got %0d", flag_names[k],
                           want.flags[k], got.flags[k]);
                end
            end
        end
    endfunction

    // watch both channels and the register port at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we) min_len = i_cfg_wdata;
            if (i_in_valid && o_in_ready) absorb_byte(i_data_byte, i_last_byte);
            if (o_out_valid && i_out_ready) check_frame();
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int stall_left;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                for (stall_left = 400; stall_left > 0; stall_left--) @(posedge i_clk);
            end else begin
                i_out_ready <= quiet || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (is_frame_tag(c) || c == CH_HASH || (c >= CH_ZERO && c <= CH_NINE));
        return c;
    endfunction

    function automatic void push_value();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 15) pkt.push_back(CH_MINUS);
        else if (r < 22) pkt.push_back(CH_PLUS);
        else if (r < 25) begin
            pkt.push_back(CH_MINUS);
            pkt.push_back(CH_PLUS);
        end
        r = $urandom_range(0, 99);
        if (r < 5) n = 0;
        else if (r < 80) n = $urandom_range(1, 3);
        else if (r < 95) n = $urandom_range(4, 5);
        else n = $urandom_range(6, 7);
        repeat (n) pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        // a stray byte ends the value, unless it is a sign with nothing before it; digits after it are dropped
        if ($urandom_range(0, 99) < 6) begin
            pkt.push_back(junk_byte());
            pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void build_frame(input t_fault fault, input int pad);
        int         victim;
        int         k;
        logic [7:0] tag;
        victim = $urandom_range(0, 8);
        if ($urandom_range(0, 99) < 20) repeat ($urandom_range(1, 3)) pkt.push_back(junk_byte());
        for (k = 0; k < 10; k++) begin
            if (fault == FAULT_SKIP && k == victim) continue;
            tag = FRAME_TAGS[k];
            if (fault == FAULT_SWAP && k == victim) tag = FRAME_TAGS[k + 1];
            if (fault == FAULT_SWAP && k == victim + 1) tag = FRAME_TAGS[victim];
            pkt.push_back(tag);
            if (k == 0) repeat (pad) pkt.push_back(CH_ZERO);
            push_value();
            if (fault == FAULT_REPEAT && k == victim) begin
                pkt.push_back(tag);
                push_value();
            end
            if (fault == FAULT_STRAY && k == victim) begin
                pkt.push_back(FRAME_TAGS[$urandom_range(0, 9)]);
                push_value();
            end
        end
    endfunction

    function automatic void append_tail(input t_tail_form form);
        logic [7:0] x;
        x = 8'd0;
        foreach (pkt[i]) x = x ^ pkt[i];
        if (form != TAIL_NONE) pkt.push_back(CH_HASH);
        case (form)
            TAIL_GOOD:  push_str($sformatf("%0d", x));
            TAIL_BAD:   push_str($sformatf("%0d", x ^ 8'($urandom_range(1, 255))));
            TAIL_NEG: begin
                pkt.push_back(CH_MINUS);
                push_str($sformatf("%0d", (256 - int'(x)) % 256));
            end
            TAIL_WRAP:  push_str($sformatf("%0d", int'(x) + 256 * $urandom_range(1, 200)));
            TAIL_HASH2: begin
                push_str($sformatf("%0d", x));
                pkt.push_back(CH_HASH);
                push_str($sformatf("%0d", $urandom_range(0, 999)));
            end
            default: ;
        endcase
    endfunction

    task automatic drive_item(input logic [7:0] b, input logic lst);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 17) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) drive_item(pkt[i], i == pkt.size() - 1);
        frames_sent++;
    endtask

    task automatic send_random_packet(input int kind);
        int         r;
        t_tail_form tail;
        pkt.delete();
        if (kind < 58) begin
            build_frame(FAULT_NONE, 0);
            r = $urandom_range(0, 99);
            if (r < 70) tail = TAIL_GOOD;
            else if (r < 80) tail = TAIL_NEG;
            else if (r < 88) tail = TAIL_WRAP;
            else if (r < 95) tail = TAIL_HASH2;
            else tail = TAIL_BARE;
            append_tail(tail);
            if ($urandom_range(0, 9) == 0) pkt.push_back(junk_byte());
        end else if (kind < 68) begin
            build_frame(FAULT_NONE, 0);
            append_tail(TAIL_BAD);
        end else if (kind < 78) begin
            build_frame(t_fault'($urandom_range(1, 4)), 0);
            append_tail(TAIL_GOOD);
        end else if (kind < 84) begin
            build_frame(FAULT_NONE, 0);
            r = $urandom_range(1, pkt.size());
            while (pkt.size() > r) void'(pkt.pop_back());
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 97) begin
            build_frame(FAULT_NONE, 0);
            append_tail(TAIL_GOOD);
            r = $urandom_range(1, pkt.size());
            while (pkt.size() > r) void'(pkt.pop_back());
        end else if (kind < 99) begin
            repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
        end else begin
            // overlong: pad the first field past the byte limit
            build_frame(FAULT_NONE, 250);
            append_tail(TAIL_GOOD);
        end
        send_packet();
    endtask

    task automatic set_min_length(input logic [7:0] level);
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= level;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int          p;
        logic [7:0]  level;
        int unsigned first_byte;
        int unsigned first_frame;
        errors       = 0;
        bytes_sent   = 0;
        frames_sent  = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = 8'd0;
        i_last_byte  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_rows[r]) begin
            pkt.delete();
            push_str(frame_rows[r].body);
            append_tail(frame_rows[r].tail);
            row_notes.push_back('{frame_rows[r].typed, frame_rows[r].status});
            send_packet();
        end

        for (p = 0; p < 7; p++) begin
            case (p)
                0, 6:    level = 8'd10;
                1:       level = 8'd0;
                2:       level = 8'd255;
                4:       level = 8'd24;
                default: level = 8'($urandom_range(1, 254));
            endcase
            set_min_length(level);
            quiet = (p == 3);
            if (p == 2) send_random_packet(99);
            if (p == 5) begin
                // hold the output side and keep offering short packets
                hold_request = 1'b1;
                repeat (24) send_random_packet(97);
            end
            first_byte  = bytes_sent;
            first_frame = frames_sent;
            while (bytes_sent - first_byte < 110 || frames_sent - first_frame < 3)
                send_random_packet($urandom_range(0, 99));
        end

        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
